// ----- sv/assert_macros.svh -----
// Assertion helpers for the flow cache RTL.
// Both expect signals named clock and reset in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_HOLDS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/fac_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fac_pkg;

   localparam int SLOTS   = 16;
   localparam int SLOT_W  = 4;
   localparam int KEY_W   = 32;
   localparam int CNT_W   = 32;
   localparam int STAMP_W = 32;
   localparam int FILL_W  = 5;

   // stamps at or above this never win the LRU scan; slot 0 is taken when none is below it
   localparam logic [30:0] STAMP_LIMIT = 31'h4000_0000;

   localparam logic MODE_RR  = 1'b0;
   localparam logic MODE_LRU = 1'b1;

   localparam logic REG_EVICTION_MODE = 1'b0;

   typedef logic [SLOT_W-1:0] slot_idx_type;

   typedef struct packed {
      logic [FILL_W-1:0]             fill;
      logic [SLOTS-1:0][KEY_W-1:0]   keys;
      logic [SLOTS-1:0][CNT_W-1:0]   counts;
      logic [SLOTS-1:0][STAMP_W-1:0] stamps;
   } row_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_EVAL,
      ST_SCAN,
      ST_WRITE
   } fsm_state_type;

   typedef enum logic [1:0] {
      KIND_HIT,
      KIND_FILL,
      KIND_EVICT
   } kind_type;

endpackage

`default_nettype wire

// ----- sv/fac_mod.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Key mod BUCKET_COUNT by reciprocal multiplication:
// quotient estimate (never high, at most one low), remainder, one correction.
module fac_mod #(
   parameter int BUCKET_COUNT = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [31:0]          key,
   output logic                      done,
   output logic [((BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1)-1:0] bucket
);

   localparam int AW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   // floor((2^32 - 1) / N) >= 2^32 / N - 1, so the estimate is off by at most one
   localparam logic [31:0] RECIP   = 32'(64'h0000_0000_FFFF_FFFF / 64'(BUCKET_COUNT));
   localparam logic [31:0] DIVISOR = 32'(BUCKET_COUNT);

   logic          v0_ff, v1_ff, v2_ff;
   logic [31:0]   key_ff;
   logic [31:0]   quot_ff, quot_in;
   logic [31:0]   rem_ff, rem_in;
   logic [63:0]   product;
   logic [31:0]   rem_fix;

   always_comb begin
      product = 64'(key_ff) * 64'(RECIP);
      quot_in = product[63:32];
      // remainder estimate lies in [0, 2N)
      rem_in  = key_ff - quot_ff * DIVISOR;
      rem_fix = (rem_ff >= DIVISOR) ? (rem_ff - DIVISOR) : rem_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= start;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         key_ff <= key;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   assign done   = v2_ff;
   assign bucket = rem_fix[AW-1:0];

endmodule

`default_nettype wire

// ----- sv/fac_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One row per bucket: 16 key/count/stamp slots plus fill pointer.
module fac_ram #(
   parameter int BUCKET_COUNT = 1024
) (
   input  wire logic                 clock,
   input  wire fac_pkg::ram_ctl_type ctl,
   input  wire logic [((BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1)-1:0] addr,
   input  wire fac_pkg::row_type     wdata,
   output fac_pkg::row_type          rdata
);

   fac_pkg::row_type mem [BUCKET_COUNT];
   fac_pkg::row_type rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[addr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- sv/fac_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fac_ctrl #(
   parameter int BUCKET_COUNT = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [31:0]          flow_key,
   input  wire logic                 eviction_mode,
   output logic                      busy,
   output logic                      mod_start,
   input  wire logic                 mod_done,
   input  wire logic [((BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1)-1:0] mod_bucket,
   output fac_pkg::ram_ctl_type      ram_ctl,
   output logic [((BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1)-1:0] ram_addr,
   output fac_pkg::row_type          ram_wdata,
   input  wire fac_pkg::row_type     ram_rdata,
   output logic                      rsp_strobe,
   output logic                      rsp_hit,
   output logic                      rsp_evicted,
   output logic [31:0]               rsp_victim_key,
   output logic [31:0]               rsp_victim_count
);

`include "assert_macros.svh"

   localparam int AW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam logic [AW-1:0] LAST_ROW = AW'(BUCKET_COUNT - 1);

   fac_pkg::fsm_state_type state_ff, state_in;
   fac_pkg::kind_type      kind_ff;
   fac_pkg::slot_idx_type  slot_ff, rr_ff, scan_ff, hit_idx;
   logic [AW-1:0]          clr_ff, bucket_ff;
   logic [31:0]            key_ff, pkt_ff, pkt_in;
   logic [30:0]            min_ff;
   logic [fac_pkg::SLOTS-1:0] match;
   logic                   hit_any, fill_free, scan_less;
   logic                   rsp_strobe_ff, rsp_hit_ff, rsp_evicted_ff;
   logic [31:0]            rsp_victim_key_ff, rsp_victim_count_ff;

   // slot match: independent compares, lowest index wins
   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < fac_pkg::SLOTS; i++) begin
         match[i] = (ram_rdata.keys[i] == key_ff);
      end
      for (int i = fac_pkg::SLOTS - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = fac_pkg::SLOT_W'(i);
         end
      end
      hit_any   = |match;
      fill_free = (ram_rdata.fill < fac_pkg::FILL_W'(fac_pkg::SLOTS));
      scan_less = (ram_rdata.stamps[scan_ff] < {1'b0, min_ff});
      pkt_in    = pkt_ff + 32'd1;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fac_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_ROW) state_in = fac_pkg::ST_IDLE;
         end
         fac_pkg::ST_IDLE: begin
            if (start) state_in = fac_pkg::ST_MOD;
         end
         fac_pkg::ST_MOD: begin
            if (mod_done) state_in = fac_pkg::ST_EVAL;
         end
         fac_pkg::ST_EVAL: begin
            if (hit_any || fill_free || (eviction_mode == fac_pkg::MODE_RR)) begin
               state_in = fac_pkg::ST_WRITE;
            end else begin
               state_in = fac_pkg::ST_SCAN;
            end
         end
         fac_pkg::ST_SCAN: begin
            if (scan_ff == fac_pkg::slot_idx_type'(fac_pkg::SLOTS - 1)) begin
               state_in = fac_pkg::ST_WRITE;
            end
         end
         fac_pkg::ST_WRITE: state_in = fac_pkg::ST_IDLE;
         default:           state_in = fac_pkg::ST_IDLE;
      endcase
   end

   // outputs toward the memory and modulo unit
   always_comb begin
      ram_ctl   = '0;
      ram_addr  = bucket_ff;
      ram_wdata = ram_rdata;
      mod_start = 1'b0;
      busy      = 1'b1;
      unique case (state_ff)
         fac_pkg::ST_CLEAR: begin
            ram_ctl.wr_en = 1'b1;
            ram_addr      = clr_ff;
            ram_wdata     = '0;
         end
         fac_pkg::ST_IDLE: begin
            busy      = 1'b0;
            mod_start = start;
         end
         fac_pkg::ST_MOD: begin
            ram_ctl.rd_en = mod_done;
            ram_addr      = mod_bucket;
         end
         fac_pkg::ST_WRITE: begin
            ram_ctl.wr_en = 1'b1;
            ram_wdata.keys[slot_ff]   = key_ff;
            ram_wdata.counts[slot_ff] = (kind_ff == fac_pkg::KIND_HIT) ?
                                        ram_rdata.counts[slot_ff] + 32'd1 : 32'd1;
            ram_wdata.stamps[slot_ff] = pkt_in;
            if (kind_ff == fac_pkg::KIND_FILL) begin
               ram_wdata.fill = ram_rdata.fill + 5'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fac_pkg::ST_CLEAR;
         clr_ff        <= '0;
         rr_ff         <= '0;
         pkt_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == fac_pkg::ST_WRITE);
         case (state_ff)
            fac_pkg::ST_CLEAR: clr_ff <= clr_ff + AW'(1);
            fac_pkg::ST_EVAL: begin
               if (!hit_any && !fill_free && (eviction_mode == fac_pkg::MODE_RR)) begin
                  rr_ff <= rr_ff + 4'd1;
               end
            end
            fac_pkg::ST_WRITE: begin
               pkt_ff <= pkt_in;
            end
            default: ;
         endcase
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      case (state_ff)
         fac_pkg::ST_IDLE: begin
            if (start) key_ff <= flow_key;
         end
         fac_pkg::ST_MOD: begin
            if (mod_done) bucket_ff <= mod_bucket;
         end
         fac_pkg::ST_EVAL: begin
            scan_ff <= '0;
            min_ff  <= fac_pkg::STAMP_LIMIT;
            if (hit_any) begin
               kind_ff <= fac_pkg::KIND_HIT;
               slot_ff <= hit_idx;
            end else if (fill_free) begin
               kind_ff <= fac_pkg::KIND_FILL;
               slot_ff <= ram_rdata.fill[fac_pkg::SLOT_W-1:0];
            end else begin
               kind_ff <= fac_pkg::KIND_EVICT;
               slot_ff <= (eviction_mode == fac_pkg::MODE_RR) ? rr_ff : '0;
            end
         end
         fac_pkg::ST_SCAN: begin
            scan_ff <= scan_ff + 4'd1;
            if (scan_less) begin
               min_ff  <= ram_rdata.stamps[scan_ff][30:0];
               slot_ff <= scan_ff;
            end
         end
         fac_pkg::ST_WRITE: begin
            rsp_hit_ff     <= (kind_ff == fac_pkg::KIND_HIT);
            rsp_evicted_ff <= (kind_ff == fac_pkg::KIND_EVICT);
            if (kind_ff == fac_pkg::KIND_EVICT) begin
               rsp_victim_key_ff   <= ram_rdata.keys[slot_ff];
               rsp_victim_count_ff <= ram_rdata.counts[slot_ff];
            end else begin
               rsp_victim_key_ff   <= '0;
               rsp_victim_count_ff <= '0;
            end
         end
         default: ;
      endcase
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_victim_key   = rsp_victim_key_ff;
   assign rsp_victim_count = rsp_victim_count_ff;

   `ASSERT_NEXT(a_strobe_after_write, state_ff == fac_pkg::ST_WRITE, rsp_strobe_ff, "no result strobe after write-back")
   `ASSERT_HOLDS(a_hit_xor_evict, rsp_strobe_ff, !(rsp_hit_ff && rsp_evicted_ff), "hit and eviction together")
   `ASSERT_HOLDS(a_evict_full, (state_ff == fac_pkg::ST_WRITE) && (kind_ff == fac_pkg::KIND_EVICT), ram_rdata.fill == fac_pkg::FILL_W'(fac_pkg::SLOTS), "eviction from a bucket that is not full")
   `ASSERT_HOLDS(a_write_states, ram_ctl.wr_en, (state_ff == fac_pkg::ST_CLEAR) || (state_ff == fac_pkg::ST_WRITE), "memory written outside clear or write-back")
   `ASSERT_HOLDS(a_mod_start_idle, mod_start, state_ff == fac_pkg::ST_IDLE, "modulo unit restarted mid transaction")

endmodule

`default_nettype wire

// ----- sv/flow_aggregation_cache_evict.sv -----
// Order: a transaction accepted on start runs key mod bucket count by reciprocal multiply,
//   one row read, an LRU stamp scan only when the bucket is full and the LRU victim is used,
//   and one row write-back; its result shows on rsp_strobe and busy drops with the strobe.
// A new transaction is taken only after the previous one has shown its result.
// Reset: synchronous; afterwards a clearing pass writes BUCKET_COUNT zero rows, one per cycle,
//   with busy high. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none

module flow_aggregation_cache_evict #(
   parameter int BUCKET_COUNT = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // command channel
   input  wire logic        start,
   output logic             busy,
   input  wire logic [31:0] req_flow_key,
   // result channel, one transaction per strobe
   output logic             rsp_strobe,
   output logic             rsp_hit,
   output logic             rsp_evicted,
   output logic [31:0]      rsp_victim_key,
   output logic [31:0]      rsp_victim_count,
   // register port
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   localparam int AW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;

   logic                 eviction_mode_ff;
   logic                 reg_hit;
   logic                 mod_start, mod_done;
   logic [AW-1:0]        mod_bucket, ram_addr;
   fac_pkg::ram_ctl_type ram_ctl;
   fac_pkg::row_type     ram_wdata, ram_rdata;

   // Register decode: word address is paddr[2], byte lanes ignored.
   assign reg_hit = (paddr[2] == fac_pkg::REG_EVICTION_MODE) && (paddr[1:0] == 2'b00 ||
                    paddr[1:0] != 2'b00);
   assign pready  = 1'b1;
   assign prdata  = reg_hit ? {31'd0, eviction_mode_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eviction_mode_ff <= fac_pkg::MODE_RR;
      end else if (psel && penable && pwrite && pready && reg_hit) begin
         eviction_mode_ff <= pwdata[0];
      end
   end

   // Key reduction to a bucket index.
   fac_mod #(
      .BUCKET_COUNT(BUCKET_COUNT)
   ) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .key   (req_flow_key),
      .done  (mod_done),
      .bucket(mod_bucket)
   );

   // Bucket rows: slots, counts, stamps and fill pointer side by side.
   fac_ram #(
      .BUCKET_COUNT(BUCKET_COUNT)
   ) u_ram (
      .clock(clock),
      .ctl  (ram_ctl),
      .addr (ram_addr),
      .wdata(ram_wdata),
      .rdata(ram_rdata)
   );

   // Sequencer: clear pass, read, match/fill/victim select, write-back, result.
   fac_ctrl #(
      .BUCKET_COUNT(BUCKET_COUNT)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .flow_key        (req_flow_key),
      .eviction_mode   (eviction_mode_ff),
      .busy            (busy),
      .mod_start       (mod_start),
      .mod_done        (mod_done),
      .mod_bucket      (mod_bucket),
      .ram_ctl         (ram_ctl),
      .ram_addr        (ram_addr),
      .ram_wdata       (ram_wdata),
      .ram_rdata       (ram_rdata),
      .rsp_strobe      (rsp_strobe),
      .rsp_hit         (rsp_hit),
      .rsp_evicted     (rsp_evicted),
      .rsp_victim_key  (rsp_victim_key),
      .rsp_victim_count(rsp_victim_count)
   );

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

// Flow counter cache bench: keys go in through start/busy, one lookup transaction
// comes back per key on rsp_strobe. A cycle-free model of the cache (buckets,
// slots, fill pointers, use stamps, round-robin pointer) predicts hit/evict
// and the victim for every accepted key.
module testbench;

   localparam int BUCKETS = 1024;
   localparam int CELLS   = BUCKETS * fac_pkg::SLOTS;

   typedef struct packed {
      logic        hit;
      logic        evicted;
      logic [31:0] victim_key;
      logic [31:0] victim_count;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_flow_key = '0;
   logic        rsp_strobe;
   logic        rsp_hit;
   logic        rsp_evicted;
   logic [31:0] rsp_victim_key;
   logic [31:0] rsp_victim_count;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // keys waiting to be presented, and lookups waiting for their strobe
   logic [31:0]       key_queue[$];
   lookup_result_type expected_lookups[$];
   int                sender_idle_pct = 0;
   int                fault_count = 0;

   // cache shadow; bit arrays start at zero, matching the post-reset clearing pass
   bit [31:0]             slot_key_model   [0:CELLS-1];
   bit [31:0]             slot_count_model [0:CELLS-1];
   bit [31:0]             slot_stamp_model [0:CELLS-1];
   bit [4:0]              fill_model       [0:BUCKETS-1];
   fac_pkg::slot_idx_type rr_victim_model = '0;
   bit [31:0]             packet_clock_model = '0;
   logic                  evict_mode_model = fac_pkg::MODE_RR;

   flow_aggregation_cache_evict #(.BUCKET_COUNT(BUCKETS)) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_flow_key     (req_flow_key),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_evicted      (rsp_evicted),
      .rsp_victim_key   (rsp_victim_key),
      .rsp_victim_count (rsp_victim_count),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One packet through the cache: hit on the lowest matching slot, else fill the
   // next free slot, else evict (round-robin or least recently stamped).
   function automatic lookup_result_type cache_lookup(input logic [31:0] key);
      lookup_result_type res;
      int                base;
      int                fill;
      int                victim;
      bit                found;
      bit [31:0]         oldest;
      res    = '0;
      base   = (key % BUCKETS) * fac_pkg::SLOTS;
      found  = 1'b0;
      victim = 0;
      packet_clock_model = packet_clock_model + 32'd1;
      for (int i = 0; i < fac_pkg::SLOTS; i++) begin
         if (!found && slot_key_model[base + i] == key) begin
            found = 1'b1;
            slot_count_model[base + i] = slot_count_model[base + i] + 32'd1;
            slot_stamp_model[base + i] = packet_clock_model;
            res.hit = 1'b1;
         end
      end
      if (found)
         return res;
      fill = fill_model[key % BUCKETS];
      if (fill < fac_pkg::SLOTS) begin
         slot_key_model[base + fill]   = key;
         slot_count_model[base + fill] = 32'd1;
         slot_stamp_model[base + fill] = packet_clock_model;
         fill_model[key % BUCKETS]     = 5'(fill + 1);
         return res;
      end
      if (evict_mode_model == fac_pkg::MODE_RR) begin
         victim = rr_victim_model;
         rr_victim_model = rr_victim_model + 1'b1;
      end else begin
         // stamps at or past the limit are never picked; slot 0 if none qualifies
         oldest = {1'b0, fac_pkg::STAMP_LIMIT};
         for (int i = 0; i < fac_pkg::SLOTS; i++) begin
            if (slot_stamp_model[base + i] < oldest) begin
               oldest = slot_stamp_model[base + i];
               victim = i;
            end
         end
      end
      res.evicted      = 1'b1;
      res.victim_key   = slot_key_model[base + victim];
      res.victim_count = slot_count_model[base + victim];
      slot_key_model[base + victim]   = key;
      slot_count_model[base + victim] = 32'd1;
      slot_stamp_model[base + victim] = packet_clock_model;
      return res;
   endfunction

   // Mostly keys from a small pool in four hot buckets, so buckets fill, hit and
   // evict; the rest fully random to toggle every key bit.
   function automatic logic [31:0] draw_flow_key();
      logic [9:0]  bucket;
      logic [21:0] tag;
      if ($urandom_range(0, 99) < 12)
         return $urandom();
      case ($urandom_range(0, 3))
         0: bucket = 10'd0;
         1: bucket = 10'd5;
         2: bucket = 10'h3FF;
         default: bucket = 10'h2A5;
      endcase
      tag = 22'($urandom_range(0, 23) * 32'h0005_3A1D);
      return {tag, bucket};
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fault_count++;
      end
   endtask

   // Driver: present the next key when the current one has been taken (or none is
   // up); random gaps let start rise at any point of the block's busy window.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         req_flow_key <= '0;
      end else if (!start || busy === 1'b0) begin
         if (key_queue.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            start <= 1'b1;
            req_flow_key <= key_queue.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check the strobed result first, then record a newly accepted key,
   // so a same-edge pair never depends on event order.
   always @(posedge clock) begin : result_check
      lookup_result_type want;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (expected_lookups.size() == 0) begin
               $error("result strobe with no transaction outstanding");
               fault_count++;
            end else begin
               want = expected_lookups.pop_front();
               check_field("hit", 32'(want.hit), 32'(rsp_hit));
               check_field("evicted", 32'(want.evicted), 32'(rsp_evicted));
               check_field("victim_key", want.victim_key, rsp_victim_key);
               check_field("victim_count", want.victim_count, rsp_victim_count);
            end
         end
         if (start && busy === 1'b0)
            expected_lookups.push_back(cache_lookup(req_flow_key));
      end
   end

   // Block idle: nothing queued or presented, no result owed, busy low.
   task automatic drain_cache();
      @(negedge clock);
      while (key_queue.size() != 0 || start || busy !== 1'b0 || expected_lookups.size() != 0)
         @(negedge clock);
   endtask

   // One APB access to the mode register, a write or a read as wr selects.
   task automatic csr_access(input logic wr, input logic [31:0] data,
                             output logic [31:0] rd);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {fac_pkg::REG_EVICTION_MODE, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (pready !== 1'b1)
         @(negedge clock);
      rd = prdata;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (wr)
         evict_mode_model = data[0];
   endtask

   task automatic program_mode(input logic [31:0] data);
      logic [31:0] rd;
      csr_access(1'b1, data, rd);
      csr_access(1'b0, '0, rd);
      if (rd !== {31'b0, evict_mode_model}) begin
         $error("eviction_mode readback: expected %0h, got %0h",
                {31'b0, evict_mode_model}, rd);
         fault_count++;
      end
   endtask

   initial begin : stimulus
      logic [31:0] mode_data [4];
      int          idle_pct  [4];
      mode_data = '{32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'h0000_0001, 32'h0000_0000};
      idle_pct  = '{87, 0, 27, 87};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      drain_cache();   // covers the clearing pass

      // directed, round-robin mode, no gaps
      program_mode(32'h0000_0000);
      sender_idle_pct = 0;
      key_queue.push_back(32'h0000_0000);      // key zero matches an unused slot
      key_queue.push_back(32'h0000_0000);
      key_queue.push_back(32'hFFFF_FFFF);      // top bucket, fill
      key_queue.push_back(32'hFFFF_FFFF);      // hit
      key_queue.push_back(32'h0000_0400);      // bucket 0 miss overwrites the key-zero slot
      key_queue.push_back(32'h0000_0000);      // key zero now lands on slot 1
      for (int k = 1; k <= 17; k++)            // fill bucket 7, then force an eviction
         key_queue.push_back((32'(k) << 10) | 32'd7);
      key_queue.push_back((32'd2 << 10) | 32'd7);
      drain_cache();

      // random phases: mode alternates (upper data bits set on some writes)
      for (int p = 0; p < 4; p++) begin
         program_mode(mode_data[p]);
         sender_idle_pct = idle_pct[p];
         for (int n = 0; n < 107; n++)
            key_queue.push_back(draw_flow_key());
         drain_cache();
      end

      // trailing window to catch stray strobes
      repeat (100) @(negedge clock);
      if (fault_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
